// ===== rtl/lbg_pkg.sv =====
package lbg_pkg;

   // field widths
   localparam int MV_W     = 13;
   localparam int PCT_W    = 7;
   localparam int Q4_W     = 17;
   localparam int THR_W    = 7;
   localparam int STATUS_W = 2;

   // discharge curve, highest voltage first
   localparam int CURVE_POINTS = 17;
   localparam int SEG_W        = $clog2(CURVE_POINTS);

   localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd4200, 13'd4150, 13'd4110, 13'd4080, 13'd4020, 13'd3980, 13'd3950,
      13'd3910, 13'd3870, 13'd3820, 13'd3790, 13'd3770, 13'd3740, 13'd3680,
      13'd3450, 13'd3270, 13'd3200
   };

   localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
      7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5, 7'd2, 7'd0
   };

   // clamp window in mV * 16
   localparam logic [Q4_W-1:0] CLAMP_LO_Q4 = 17'd48000;
   localparam logic [Q4_W-1:0] CLAMP_HI_Q4 = 17'd68800;

   localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

   // interpolation divide: quotient never exceeds the largest step of the curve
   localparam int DIFF_W    = 12;
   localparam int DP_W      = 4;
   localparam int NUM_W     = DIFF_W + DP_W;
   localparam int PCT_DVD_W = NUM_W + 1;
   localparam int PCT_DVS_W = DIFF_W + 1;
   localparam int PCT_Q_W   = 4;

   // running average divide: (9*old + new + 5) / 10
   localparam int AVG_DVD_W = 21;
   localparam int AVG_DVS_W = 4;
   localparam int AVG_Q_W   = Q4_W;
   localparam logic [AVG_DVS_W-1:0] AVG_DIVISOR = 4'd10;
   localparam logic [AVG_DVD_W-1:0] AVG_ROUND   = 21'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CRITICAL = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_CHARGING = 2'd3;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_LOW_THRESHOLD      = 1'b0;
   localparam logic REG_CRITICAL_THRESHOLD = 1'b1;
   localparam logic [THR_W-1:0] LOW_THRESHOLD_RESET      = 7'd15;
   localparam logic [THR_W-1:0] CRITICAL_THRESHOLD_RESET = 7'd5;

   typedef enum logic [2:0] {
      G_IDLE,
      G_START,
      G_RUN1,
      G_SMOOTH,
      G_RUN2
   } gauge_state_type;

   typedef enum logic [1:0] {
      SOC_IDLE,
      SOC_SEG,
      SOC_LOAD,
      SOC_WAIT
   } soc_state_type;

endpackage

// ===== rtl/lbg_serdiv.sv =====
module lbg_serdiv #(
   parameter int DVD_W = lbg_pkg::PCT_DVD_W,
   parameter int DVS_W = lbg_pkg::PCT_DVS_W,
   parameter int Q_W   = lbg_pkg::PCT_Q_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [Q_W-1:0]   quotient
);
   import lbg_pkg::*;

   // restoring divider, one quotient bit per cycle; caller keeps the
   // quotient below 2**Q_W so the upper dividend bits start as remainder
   localparam int CNT_W = $clog2(Q_W + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   trial_sub;
   logic             fits;

   assign trial     = {rem_ff, quo_ff[Q_W-1]};
   assign fits      = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = DVS_W'(dividend >> Q_W);
         quo_in = dividend[Q_W-1:0];
         dvs_in = divisor;
         cnt_in = CNT_W'(Q_W);
      end else if (cnt_ff != '0) begin
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = Q_W'({quo_ff, fits});
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

// ===== rtl/lbg_soc.sv =====
module lbg_soc (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lbg_pkg::Q4_W-1:0]  vq4,
   output logic                      busy,
   output logic [lbg_pkg::PCT_W-1:0] percent
);
   import lbg_pkg::*;

   soc_state_type state_ff, state_in;

   logic [Q4_W-1:0]      v_ff, v_in;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [PCT_W-1:0]     base_ff, base_in;
   logic                 use_div_ff, use_div_in;

   logic [SEG_W-1:0]     above_cnt;
   logic                 at_top;
   logic                 at_bottom;
   logic [SEG_W-1:0]     seg_next;
   logic [Q4_W-1:0]      v2_q4;
   logic [Q4_W-1:0]      v1_q4;
   logic [DIFF_W-1:0]    diff;
   logic [DIFF_W-1:0]    gap;
   logic [DP_W-1:0]      dp;
   logic [NUM_W-1:0]     num;
   logic [PCT_DVD_W-1:0] dividend;
   logic [PCT_DVS_W-1:0] divisor;
   logic [PCT_Q_W-1:0]   quotient;
   logic                 div_start;
   logic                 div_busy;

   // segment search: the curve falls monotonically, so the number of
   // points above v (skipping the top one) is the upper end of the segment
   always_comb begin
      above_cnt = '0;
      for (int k = 1; k < CURVE_POINTS; k++) begin
         if (v_ff < {CURVE_MV[k], 4'b0000}) begin
            above_cnt = above_cnt + 1'b1;
         end
      end
   end

   assign at_top    = v_ff >= {CURVE_MV[0], 4'b0000};
   assign at_bottom = v_ff <= {CURVE_MV[CURVE_POINTS-1], 4'b0000};

   // interpolation operands
   assign seg_next = seg_ff + 1'b1;
   assign v1_q4    = {CURVE_MV[seg_ff], 4'b0000};
   assign v2_q4    = {CURVE_MV[seg_next], 4'b0000};
   assign diff     = DIFF_W'(v_ff - v2_q4);
   assign gap      = DIFF_W'(v1_q4 - v2_q4);
   assign dp       = DP_W'(CURVE_PCT[seg_ff] - CURVE_PCT[seg_next]);
   assign num      = diff * dp;
   assign dividend = {num, 1'b0} + PCT_DVD_W'(gap);
   assign divisor  = {gap, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SOC_IDLE: begin
            if (start) state_in = SOC_SEG;
         end
         SOC_SEG: begin
            state_in = (at_top || at_bottom) ? SOC_IDLE : SOC_LOAD;
         end
         SOC_LOAD: begin
            state_in = SOC_WAIT;
         end
         SOC_WAIT: begin
            if (!div_busy) state_in = SOC_IDLE;
         end
         default: begin
            state_in = SOC_IDLE;
         end
      endcase
   end

   // outputs and datapath loads
   always_comb begin
      v_in       = v_ff;
      seg_in     = seg_ff;
      base_in    = base_ff;
      use_div_in = use_div_ff;
      div_start  = 1'b0;
      case (state_ff)
         SOC_IDLE: begin
            if (start) begin
               if (vq4 < CLAMP_LO_Q4) begin
                  v_in = CLAMP_LO_Q4;
               end else if (vq4 > CLAMP_HI_Q4) begin
                  v_in = CLAMP_HI_Q4;
               end else begin
                  v_in = vq4;
               end
            end
         end
         SOC_SEG: begin
            seg_in     = above_cnt;
            use_div_in = 1'b0;
            base_in    = at_top ? PCT_FULL : PCT_EMPTY;
         end
         SOC_LOAD: begin
            div_start  = 1'b1;
            use_div_in = 1'b1;
            base_in    = CURVE_PCT[seg_next];
         end
         SOC_WAIT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff       <= v_in;
      seg_ff     <= seg_in;
      base_ff    <= base_in;
      use_div_ff <= use_div_in;
      if (reset) begin
         state_ff <= SOC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   lbg_serdiv #(
      .DVD_W (PCT_DVD_W),
      .DVS_W (PCT_DVS_W),
      .Q_W   (PCT_Q_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign busy    = state_ff != SOC_IDLE;
   assign percent = base_ff + (use_div_ff ? PCT_W'(quotient) : PCT_EMPTY);

endmodule

// ===== rtl/liion_battery_gauge_unit.sv =====
// One item at a time: the next is taken the cycle after the result loads. The 17-step
// average divider runs beside the curve interpolation unit on the raw voltage (the first
// item only seeds the average), then the unit runs again on the smoothed voltage, skipping
// its divider at or past an end of the curve; a stalled result holds the next one back.
// Reset (synchronous, active high) clears the seed, sets thresholds to 15 and 5, drops results.
module liion_battery_gauge_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lbg_pkg::MV_W-1:0]            req_battery_mv,
   input  logic                                req_charging,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lbg_pkg::PCT_W-1:0]           rsp_raw_percent,
   output logic [lbg_pkg::PCT_W-1:0]           rsp_smoothed_percent,
   output logic                                rsp_low_flag,
   output logic                                rsp_critical_flag,
   output logic [lbg_pkg::STATUS_W-1:0]        rsp_status_code,
   output logic [lbg_pkg::Q4_W-1:0]            rsp_smoothed_mv_q4,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lbg_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [lbg_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [lbg_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import lbg_pkg::*;

   gauge_state_type state_ff, state_in;

   // captured item
   logic [MV_W-1:0]      mv_ff, mv_in;
   logic                 chg_ff, chg_in;

   // running average state
   logic [Q4_W-1:0]      smooth_ff, smooth_in;
   logic                 seeded_ff, seeded_in;
   logic                 avg_run_ff, avg_run_in;

   logic [PCT_W-1:0]     raw_ff, raw_in;

   // thresholds
   logic [THR_W-1:0]     low_thr_ff, low_thr_in;
   logic [THR_W-1:0]     crit_thr_ff, crit_thr_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PCT_W-1:0]     rsp_raw_ff, rsp_raw_in;
   logic [PCT_W-1:0]     rsp_smp_ff, rsp_smp_in;
   logic                 rsp_low_ff, rsp_low_in;
   logic                 rsp_crit_ff, rsp_crit_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [Q4_W-1:0]      rsp_mv_ff, rsp_mv_in;

   logic                 accept;
   logic                 csr_write;
   logic                 out_free;
   logic [Q4_W-1:0]      xq4;
   logic [Q4_W-1:0]      soc_v;
   logic [PCT_W-1:0]     soc_pct;
   logic [AVG_DVD_W-1:0] avg_dividend;
   logic [AVG_Q_W-1:0]   avg_quotient;
   logic                 low_hit;
   logic                 crit_hit;
   logic                 units_done;
   logic                 raw_load;
   logic                 rsp_load;
   logic                 soc_start;
   logic                 soc_busy;
   logic                 avg_start;
   logic                 avg_busy;

   // ---------------------------------------------------------------
   // Handshake: take an item only when the sequencer is idle. The
   // result register sits apart, so a waiting result does not block.
   // ---------------------------------------------------------------
   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != G_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign xq4 = {mv_ff, 4'b0000};

   // 9*old + new + 5; the divide by ten runs serially below
   assign avg_dividend = AVG_DVD_W'({smooth_ff, 3'b000}) + AVG_DVD_W'(smooth_ff)
                       + AVG_DVD_W'(xq4) + AVG_ROUND;

   assign units_done = !soc_busy && !avg_busy;

   // ---------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         G_IDLE: begin
            if (accept) state_in = G_START;
         end
         G_START: begin
            state_in = G_RUN1;
         end
         G_RUN1: begin
            if (units_done) state_in = G_SMOOTH;
         end
         G_SMOOTH: begin
            state_in = G_RUN2;
         end
         G_RUN2: begin
            if (!soc_busy && out_free) state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Sequencer outputs: unit starts and register loads
   // ---------------------------------------------------------------
   always_comb begin
      soc_start = 1'b0;
      avg_start = 1'b0;
      soc_v     = xq4;
      raw_load  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         G_IDLE: begin
         end
         G_START: begin
            // raw percentage and average divide run side by side
            soc_start = 1'b1;
            avg_start = seeded_ff;
         end
         G_RUN1: begin
            raw_load = units_done;
         end
         G_SMOOTH: begin
            soc_start = 1'b1;
            soc_v     = smooth_ff;
         end
         G_RUN2: begin
            rsp_load = !soc_busy && out_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Item capture, average and raw percentage
   // ---------------------------------------------------------------
   always_comb begin
      mv_in      = mv_ff;
      chg_in     = chg_ff;
      smooth_in  = smooth_ff;
      seeded_in  = seeded_ff;
      avg_run_in = avg_run_ff;
      raw_in     = raw_ff;
      if (accept) begin
         mv_in  = req_battery_mv;
         chg_in = req_charging;
      end
      if (state_ff == G_START) begin
         avg_run_in = seeded_ff;
         // first sample after reset only seeds the average
         if (!seeded_ff) begin
            smooth_in = xq4;
            seeded_in = 1'b1;
         end
      end
      if (raw_load) begin
         raw_in = soc_pct;
         if (avg_run_ff) smooth_in = avg_quotient;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   assign low_hit  = raw_ff <= low_thr_ff;
   assign crit_hit = raw_ff <= crit_thr_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_smp_in    = rsp_smp_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_crit_in   = rsp_crit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mv_in     = rsp_mv_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_raw_in   = raw_ff;
         rsp_smp_in   = soc_pct;
         rsp_low_in   = low_hit;
         rsp_crit_in  = crit_hit;
         rsp_mv_in    = smooth_ff;
         // charging outranks critical, critical outranks low
         if (chg_ff) begin
            rsp_status_in = STATUS_CHARGING;
         end else if (crit_hit) begin
            rsp_status_in = STATUS_CRITICAL;
         end else if (low_hit) begin
            rsp_status_in = STATUS_LOW;
         end else begin
            rsp_status_in = STATUS_GOOD;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Register file: word aligned, two threshold registers
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      low_thr_in  = low_thr_ff;
      crit_thr_in = crit_thr_ff;
      if (csr_write) begin
         if (paddr[2] == REG_CRITICAL_THRESHOLD) begin
            crit_thr_in = pwdata[THR_W-1:0];
         end else begin
            low_thr_in = pwdata[THR_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_CRITICAL_THRESHOLD) ? CSR_DATA_W'(crit_thr_ff)
                                                        : CSR_DATA_W'(low_thr_ff);

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      mv_ff         <= mv_in;
      chg_ff        <= chg_in;
      smooth_ff     <= smooth_in;
      avg_run_ff    <= avg_run_in;
      raw_ff        <= raw_in;
      rsp_raw_ff    <= rsp_raw_in;
      rsp_smp_ff    <= rsp_smp_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_crit_ff   <= rsp_crit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mv_ff     <= rsp_mv_in;
      if (reset) begin
         state_ff     <= G_IDLE;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         low_thr_ff   <= LOW_THRESHOLD_RESET;
         crit_thr_ff  <= CRITICAL_THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
         low_thr_ff   <= low_thr_in;
         crit_thr_ff  <= crit_thr_in;
      end
   end

   // ---------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------
   lbg_soc u_soc (
      .clock   (clock),
      .reset   (reset),
      .start   (soc_start),
      .vq4     (soc_v),
      .busy    (soc_busy),
      .percent (soc_pct)
   );

   lbg_serdiv #(
      .DVD_W (AVG_DVD_W),
      .DVS_W (AVG_DVS_W),
      .Q_W   (AVG_Q_W)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (avg_start),
      .dividend (avg_dividend),
      .divisor  (AVG_DIVISOR),
      .busy     (avg_busy),
      .quotient (avg_quotient)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_percent      = rsp_raw_ff;
   assign rsp_smoothed_percent = rsp_smp_ff;
   assign rsp_low_flag         = rsp_low_ff;
   assign rsp_critical_flag    = rsp_crit_ff;
   assign rsp_status_code      = rsp_status_ff;
   assign rsp_smoothed_mv_q4   = rsp_mv_ff;

endmodule

// ===== rtl/lbg_checker.sv =====
module lbg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [lbg_pkg::PCT_W-1:0]      rsp_raw_percent,
   input logic [lbg_pkg::PCT_W-1:0]      rsp_smoothed_percent,
   input logic                           rsp_low_flag,
   input logic                           rsp_critical_flag,
   input logic [lbg_pkg::STATUS_W-1:0]   rsp_status_code,
   input logic [lbg_pkg::Q4_W-1:0]       rsp_smoothed_mv_q4
);
   import lbg_pkg::*;

   // one item at a time: the input side closes right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in progress");

   // a stalled result stays valid
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_raw_percent <= PCT_FULL && rsp_smoothed_percent <= PCT_FULL)
      else $error("percentage above full scale");

   // good status means neither flag raised; critical status needs its flag
   a_status_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_code == STATUS_GOOD || rsp_status_code == STATUS_CRITICAL)
      |-> (rsp_status_code == STATUS_CRITICAL) == rsp_critical_flag
          && (rsp_status_code == STATUS_CRITICAL || !rsp_low_flag))
      else $error("status code disagrees with flags");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_smoothed_mv_q4) && $stable(rsp_status_code))
      else $error("stalled result changed");

endmodule

bind liion_battery_gauge_unit lbg_checker u_lbg_checker (.*);
